>>> design/tdc_pkg.sv
// shared types and constants for the throttle detent calibrator
// no dependencies; used by every module under design/
`timescale 1ns / 1ps
package tdc_pkg;

  localparam int unsigned PctW   = 7;
  localparam int unsigned TickW  = 16;
  localparam int unsigned PulseW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 40;

  localparam logic [PctW-1:0]   PctMax    = 7'd100;
  localparam logic [PulseW-1:0] PulseBase = 11'd1000;

  // calibration phase, also reported as status
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_AWAIT   = 3'd1,
    PH_TRACK   = 3'd2,
    PH_SETTLE  = 3'd3,
    PH_DONE    = 3'd4,
    PH_TIMEOUT = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    STG_IDLE = 2'd0,
    STG_MID  = 2'd1,
    STG_MAX  = 2'd2
  } stage_e;

  // mode field of a request
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEADBAND      = 3'd0,
    REG_FIRST_TIMEOUT = 3'd1,
    REG_LATER_TIMEOUT = 3'd2,
    REG_SETTLE_IDLE   = 3'd3,
    REG_SETTLE_MID    = 3'd4,
    REG_SETTLE_MAX    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PctW-1:0]  deadband;
    logic [TickW-1:0] first_timeout;
    logic [TickW-1:0] later_timeout;
    logic [TickW-1:0] settle_idle;
    logic [TickW-1:0] settle_mid;
    logic [TickW-1:0] settle_max;
  } cfg_t;

  typedef struct packed {
    logic [PctW-1:0]   detent_top;
    logic [PctW-1:0]   detent_mid;
    logic [PctW-1:0]   detent_idle;
    logic [1:0]        stage;
    logic [2:0]        status;
    logic [PulseW-1:0] pulse_width_us;
  } res_t;

endpackage

>>> design/tdc_cfg_regs.sv
// configuration register file for the throttle detent calibrator
// depends on tdc_pkg
`timescale 1ns / 1ps
module tdc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tdc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output tdc_pkg::cfg_t                 cfg_o
);

  tdc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdc_pkg::REG_DEADBAND:      cfg_d.deadband      = cfg_wdata_i[tdc_pkg::PctW-1:0];
        tdc_pkg::REG_FIRST_TIMEOUT: cfg_d.first_timeout = cfg_wdata_i;
        tdc_pkg::REG_LATER_TIMEOUT: cfg_d.later_timeout = cfg_wdata_i;
        tdc_pkg::REG_SETTLE_IDLE:   cfg_d.settle_idle   = cfg_wdata_i;
        tdc_pkg::REG_SETTLE_MID:    cfg_d.settle_mid    = cfg_wdata_i;
        tdc_pkg::REG_SETTLE_MAX:    cfg_d.settle_max    = cfg_wdata_i;
        default: ; // unused indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband      <= 7'd5;
      cfg_q.first_timeout <= 16'd20000;
      cfg_q.later_timeout <= 16'd10000;
      cfg_q.settle_idle   <= 16'd4000;
      cfg_q.settle_mid    <= 16'd2000;
      cfg_q.settle_max    <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/tdc_core.sv
// calibration state and its one-step update for the throttle detent calibrator
// depends on tdc_pkg
`timescale 1ns / 1ps
module tdc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tdc_pkg::cfg_t             cfg_i,
  input  logic                      step_i,
  input  logic                      mode_i,
  input  logic [tdc_pkg::PctW-1:0]  reading_i,
  output tdc_pkg::res_t             res_o
);

  tdc_pkg::phase_e phase_q, phase_d;
  logic [1:0]                stage_q, stage_d;
  logic [tdc_pkg::TickW-1:0] cnt_q, cnt_d;
  logic [tdc_pkg::PctW-1:0]  ref_q, ref_d;
  logic [tdc_pkg::PctW-1:0]  drive_q, drive_d;
  logic [tdc_pkg::PctW-1:0]  det_q [3];
  logic [tdc_pkg::PctW-1:0]  det_d [3];

  logic [1:0]                slot;
  logic [tdc_pkg::PctW-1:0]  diff;
  logic                      moved;
  logic [tdc_pkg::TickW-1:0] cnt_inc;
  logic [tdc_pkg::TickW-1:0] timeout_lim;
  logic [tdc_pkg::TickW-1:0] settle_lim;
  logic                      timed_out;
  logic                      settled;
  logic                      start;
  logic [tdc_pkg::PctW-1:0]  pct;

  // a stage index of 3 never occurs; treat it as the max stage
  assign slot = (stage_q == tdc_pkg::STG_IDLE) ? tdc_pkg::STG_IDLE :
                (stage_q == tdc_pkg::STG_MID)  ? tdc_pkg::STG_MID  : tdc_pkg::STG_MAX;

  assign diff  = (reading_i > ref_q) ? (reading_i - ref_q) : (ref_q - reading_i);
  assign moved = diff > cfg_i.deadband;

  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

  assign timeout_lim = (slot == tdc_pkg::STG_IDLE) ? cfg_i.first_timeout : cfg_i.later_timeout;
  assign settle_lim  = (slot == tdc_pkg::STG_IDLE) ? cfg_i.settle_idle :
                       (slot == tdc_pkg::STG_MID)  ? cfg_i.settle_mid  : cfg_i.settle_max;

  assign timed_out = cnt_inc >= timeout_lim;
  assign settled   = cnt_inc >= settle_lim;
  assign start     = mode_i == tdc_pkg::MODE_START;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (start) begin
        phase_d = tdc_pkg::PH_AWAIT;
      end else begin
        unique case (phase_q)
          tdc_pkg::PH_AWAIT: begin
            if (moved)          phase_d = tdc_pkg::PH_TRACK;
            else if (timed_out) phase_d = tdc_pkg::PH_TIMEOUT;
          end
          tdc_pkg::PH_TRACK: begin
            if (!moved) phase_d = tdc_pkg::PH_SETTLE;
          end
          tdc_pkg::PH_SETTLE: begin
            if (!moved && settled) begin
              phase_d = (slot == tdc_pkg::STG_MAX) ? tdc_pkg::PH_DONE : tdc_pkg::PH_AWAIT;
            end
          end
          default: ; // idle, done and timed out hold
        endcase
      end
    end
  end

  // datapath registers
  always_comb begin
    stage_d = stage_q;
    cnt_d   = cnt_q;
    ref_d   = ref_q;
    drive_d = drive_q;
    det_d   = det_q;
    if (step_i) begin
      if (start) begin
        stage_d = tdc_pkg::STG_IDLE;
        ref_d   = reading_i;
        cnt_d   = '0;
      end else begin
        unique case (phase_q)
          tdc_pkg::PH_AWAIT: begin
            cnt_d = cnt_inc;
            if (moved) begin
              drive_d = reading_i;
              ref_d   = reading_i;
            end
          end
          tdc_pkg::PH_TRACK: begin
            drive_d = reading_i;
            if (moved) ref_d = reading_i;
            else       cnt_d = '0;
          end
          tdc_pkg::PH_SETTLE: begin
            if (moved) begin
              ref_d   = reading_i;
              drive_d = reading_i;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
              if (settled) begin
                det_d[slot] = ref_q;
                drive_d     = '0;
                cnt_d       = '0;
                if (slot == tdc_pkg::STG_MAX) begin
                  stage_d = tdc_pkg::STG_MAX;
                end else begin
                  stage_d = slot + 2'd1;
                  ref_d   = reading_i;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tdc_pkg::PH_IDLE;
      stage_q <= '0;
      cnt_q   <= '0;
      ref_q   <= '0;
      drive_q <= '0;
      det_q   <= '{default: '0};
    end else begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
      ref_q   <= ref_d;
      drive_q <= drive_d;
      det_q   <= det_d;
    end
  end

  // result of this step, from the updated state
  assign pct = (drive_d > tdc_pkg::PctMax) ? tdc_pkg::PctMax : drive_d;

  always_comb begin
    res_o.pulse_width_us = tdc_pkg::PulseBase
                         + {1'b0, pct, 3'b000}
                         + {3'b000, pct, 1'b0};
    res_o.status      = phase_d;
    res_o.stage       = stage_d;
    res_o.detent_idle = det_d[0];
    res_o.detent_mid  = det_d[1];
    res_o.detent_top  = det_d[2];
  end

endmodule

>>> design/throttle_detent_calibrator.sv
// top level of the throttle detent calibrator: stream ports, input and result registers
// depends on tdc_pkg, tdc_cfg_regs, tdc_core
`timescale 1ns / 1ps
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: reading; tuser: mode
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: pulse, status, stage, detents
// cfg      | in        | cfg_we_i (no wait)            | cfg_idx_i, cfg_wdata_i
//
// every request yields exactly one result: it is held in the input register,
// then the state update and result are written into the result register;
// a new request is taken every cycle while the output side is not stalled
// a stall on m_axis holds the result register and, through it, the input
// register; s_axis_tready drops only while both are full and blocked
// reset is asynchronous, active low; it restores default registers and idle phase
module throttle_detent_calibrator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tdc_pkg::InDataW-1:0]      s_axis_tdata,  // [6:0] reading, [7] zero
  input  logic                             s_axis_tuser,  // [0] mode
  // stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tdc_pkg::OutDataW-1:0]     m_axis_tdata,  // [10:0] pulse_width_us,
                                                          // [13:11] status, [15:14] stage,
                                                          // [22:16] detent_idle,
                                                          // [29:23] detent_mid,
                                                          // [36:30] detent_top, [39:37] zero
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [tdc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tdc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  tdc_pkg::cfg_t cfg;
  tdc_pkg::res_t res;

  // input register
  logic                      in_vld_q, in_vld_d;
  logic                      in_mode_q;
  logic [tdc_pkg::PctW-1:0]  in_reading_q;

  // result register
  logic                      out_vld_q, out_vld_d;
  tdc_pkg::res_t             out_res_q;

  logic advance;
  logic step;
  logic accept;

  // result register can take a new value when empty or being drained
  assign advance = !out_vld_q || m_axis_tready;
  assign step    = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = accept || (in_vld_q && !advance);
  assign out_vld_d = step || (out_vld_q && !m_axis_tready);

  tdc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tdc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .mode_i    (in_mode_q),
    .reading_i (in_reading_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_mode_q    <= s_axis_tuser;
      in_reading_q <= s_axis_tdata[tdc_pkg::PctW-1:0];
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_res_q};

endmodule
